// ===== src/opvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opvd_pkg - shared types and constants for the OBD-II PID value decoder
// Fixed-point format, divisor codes, queue entry layout and the constant
// reciprocals used by the divide-by-constant pipeline.
// ----------------------------------------------------------------------------
package opvd_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int VALUE_WIDTH   = 46;
    localparam int MAG_W         = 32;
    localparam int FX_W          = MAG_W + FRACTION_BITS;
    localparam int QR_W          = 10;                       // remainder, largest divisor 1000
    localparam int M_SHIFT       = 20;                       // r * divisor < 2^20
    localparam int M_W           = FRACTION_BITS + M_SHIFT;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] PID_MAP_LOW  = 8'h00;
    localparam logic [7:0] PID_MAP_MID  = 8'h20;
    localparam logic [7:0] PID_MAP_HIGH = 8'h40;

    localparam logic [1:0] GRP_LOW  = 2'd0;
    localparam logic [1:0] GRP_MID  = 2'd1;
    localparam logic [1:0] GRP_HIGH = 2'd2;

    typedef enum logic [3:0] {
        DEN_1, DEN_2, DEN_4, DEN_32, DEN_128, DEN_32K,
        DEN_10, DEN_20, DEN_100, DEN_200, DEN_255, DEN_1000
    } t_den;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        t_den             den;
        logic             rec;
        logic             map;
        logic [1:0]       grp;
    } t_entry;

    // floor(2^32 / d): quotient estimate, at most one short
    localparam logic [31:0] Q_10   = 32'((64'd1 << 32) / 10);
    localparam logic [31:0] Q_20   = 32'((64'd1 << 32) / 20);
    localparam logic [31:0] Q_100  = 32'((64'd1 << 32) / 100);
    localparam logic [31:0] Q_200  = 32'((64'd1 << 32) / 200);
    localparam logic [31:0] Q_255  = 32'((64'd1 << 32) / 255);
    localparam logic [31:0] Q_1000 = 32'((64'd1 << 32) / 1000);

    // ceil(2^(F+M_SHIFT) / d): exact fraction bits for any remainder below d
    localparam logic [M_W-1:0] M_10   = M_W'(((64'd1 << M_W) + 64'd9) / 10);
    localparam logic [M_W-1:0] M_20   = M_W'(((64'd1 << M_W) + 64'd19) / 20);
    localparam logic [M_W-1:0] M_100  = M_W'(((64'd1 << M_W) + 64'd99) / 100);
    localparam logic [M_W-1:0] M_200  = M_W'(((64'd1 << M_W) + 64'd199) / 200);
    localparam logic [M_W-1:0] M_255  = M_W'(((64'd1 << M_W) + 64'd254) / 255);
    localparam logic [M_W-1:0] M_1000 = M_W'(((64'd1 << M_W) + 64'd999) / 1000);

    function automatic logic den_is_pow2(input t_den d);
        unique case (d)
            DEN_1, DEN_2, DEN_4, DEN_32, DEN_128, DEN_32K: den_is_pow2 = 1'b1;
            default:                                       den_is_pow2 = 1'b0;
        endcase
    endfunction

    function automatic int unsigned den_log2(input t_den d);
        unique case (d)
            DEN_2:   den_log2 = 1;
            DEN_4:   den_log2 = 2;
            DEN_32:  den_log2 = 5;
            DEN_128: den_log2 = 7;
            DEN_32K: den_log2 = 15;
            default: den_log2 = 0;
        endcase
    endfunction

    function automatic logic [QR_W-1:0] den_value(input t_den d);
        unique case (d)
            DEN_10:   den_value = QR_W'(10);
            DEN_20:   den_value = QR_W'(20);
            DEN_100:  den_value = QR_W'(100);
            DEN_200:  den_value = QR_W'(200);
            DEN_255:  den_value = QR_W'(255);
            DEN_1000: den_value = QR_W'(1000);
            default:  den_value = QR_W'(1);
        endcase
    endfunction

    function automatic logic [31:0] den_recip_q(input t_den d);
        unique case (d)
            DEN_10:   den_recip_q = Q_10;
            DEN_20:   den_recip_q = Q_20;
            DEN_100:  den_recip_q = Q_100;
            DEN_200:  den_recip_q = Q_200;
            DEN_255:  den_recip_q = Q_255;
            DEN_1000: den_recip_q = Q_1000;
            default:  den_recip_q = '0;
        endcase
    endfunction

    function automatic logic [M_W-1:0] den_recip_m(input t_den d);
        unique case (d)
            DEN_10:   den_recip_m = M_10;
            DEN_20:   den_recip_m = M_20;
            DEN_100:  den_recip_m = M_100;
            DEN_200:  den_recip_m = M_200;
            DEN_255:  den_recip_m = M_255;
            DEN_1000: den_recip_m = M_1000;
            default:  den_recip_m = '0;
        endcase
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] w);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = w[31-i];
        end
        return r;
    endfunction

endpackage

// ===== src/opvd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opvd_if - valid/ready channels of the PID value decoder
// One interface for the response item, one for the decoded result.
// ----------------------------------------------------------------------------
interface opvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pid_code;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [7:0] data_c;
    logic [7:0] data_d;

    modport source (output valid, pid_code, data_a, data_b, data_c, data_d, input ready);
    modport sink   (input valid, pid_code, data_a, data_b, data_c, data_d, output ready);
endinterface

interface opvd_out_if;
    import opvd_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] scaled_value;
    logic                          recognised;
    logic                          is_support_map;
    logic [1:0]                    map_group;

    modport source (output valid, scaled_value, recognised, is_support_map, map_group,
                    input ready);
    modport sink   (input valid, scaled_value, recognised, is_support_map, map_group,
                    output ready);
endinterface

// ===== src/opvd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opvd_front - response classifier
// Maps the PID to its divisor and signed numerator, and captures the
// supported-PID bitmaps.
// ----------------------------------------------------------------------------
module opvd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    opvd_in_if.sink          i_item,
    input  logic             i_full,
    output logic             o_push,
    output opvd_pkg::t_entry o_entry
);
    import opvd_pkg::*;

    logic [31:0]        r_map_low, r_map_mid, r_map_high;
    logic signed [33:0] num;
    logic signed [33:0] a34, ab34, abcd34;
    logic [31:0]        abcd;
    t_den               den;
    logic               rec, map;
    logic [1:0]         grp;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    assign abcd   = {i_item.data_a, i_item.data_b, i_item.data_c, i_item.data_d};
    assign a34    = $signed({26'd0, i_item.data_a});
    assign ab34   = $signed({18'd0, i_item.data_a, i_item.data_b});
    assign abcd34 = $signed({2'd0, abcd});

    always_comb begin
        num = '0;
        den = DEN_1;
        rec = 1'b1;
        map = 1'b0;
        grp = GRP_LOW;
        unique case (i_item.pid_code)
            PID_MAP_LOW: begin
                map = 1'b1;
                grp = GRP_LOW;
            end
            PID_MAP_MID: begin
                map = 1'b1;
                grp = GRP_MID;
            end
            PID_MAP_HIGH: begin
                map = 1'b1;
                grp = GRP_HIGH;
            end
            8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h47, 8'h48, 8'h49,
            8'h4A, 8'h4B, 8'h4C, 8'h52, 8'h5A, 8'h5B: begin
                num = a34 * 34'sd100;
                den = DEN_255;
            end
            8'h05, 8'h0F, 8'h46, 8'h5C, 8'h67, 8'h68: num = a34 - 34'sd40;
            8'h06, 8'h07, 8'h08, 8'h09, 8'h2D, 8'h55, 8'h56, 8'h57, 8'h58: begin
                num = a34 * 34'sd100 - 34'sd12800;
                den = DEN_128;
            end
            8'h0A: num = a34 * 34'sd3;
            8'h0B, 8'h0D, 8'h30, 8'h33, 8'h4F: num = a34;
            8'h0C, 8'h32: begin
                num = ab34;
                den = DEN_4;
            end
            8'h0E: begin
                num = a34 - 34'sd128;
                den = DEN_2;
            end
            8'h10: begin
                num = ab34;
                den = DEN_100;
            end
            8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B: begin
                num = a34;
                den = DEN_200;
            end
            8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h59, 8'h63: num = ab34;
            8'h22: begin
                num = ab34 * 34'sd79;
                den = DEN_1000;
            end
            8'h23: num = ab34 * 34'sd10;
            8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
            8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h44: begin
                num = ab34;
                den = DEN_32K;
            end
            8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h7C: begin
                num = ab34 - 34'sd4000;
                den = DEN_100;
            end
            8'h42: begin
                num = ab34;
                den = DEN_1000;
            end
            8'h43: begin
                num = ab34 * 34'sd100;
                den = DEN_255;
            end
            8'h53: begin
                num = ab34;
                den = DEN_200;
            end
            8'h54: num = ab34 - 34'sd32767;
            8'h5D: begin
                num = a34 * 34'sd100 - 34'sd26880;
                den = DEN_128;
            end
            8'h5E: begin
                num = ab34;
                den = DEN_20;
            end
            8'h61, 8'h62, 8'h64: num = a34 - 34'sd125;
            8'h66: begin
                num = ab34;
                den = DEN_32;
            end
            8'hA6: begin
                num = abcd34;
                den = DEN_10;
            end
            default: rec = 1'b0;
        endcase
    end

    always_comb begin
        o_entry.neg = num[33];
        o_entry.mag = num[33] ? MAG_W'(-num) : MAG_W'(num);
        o_entry.den = den;
        o_entry.rec = rec;
        o_entry.map = map;
        o_entry.grp = grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_low  <= '0;
            r_map_mid  <= '0;
            r_map_high <= '0;
        end else if (o_push && map) begin
            // first bit received lands in bit 0
            priority case (grp)
                GRP_LOW:  r_map_low  <= rev32(abcd);
                GRP_MID:  r_map_mid  <= rev32(abcd);
                default:  r_map_high <= rev32(abcd);
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_map_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_item.pid_code == PID_MAP_LOW) |=> r_map_low == $past(rev32(abcd)))
        else $error("low support map not captured");
    a_map_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_push && map) |=> $stable(r_map_low) && $stable(r_map_mid) && $stable(r_map_high))
        else $error("support map changed without a map response");
`endif
endmodule

// ===== src/opvd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opvd_queue - short entry queue between classifier and scaler
// Lets the front take responses while the back end is stalled.
// ----------------------------------------------------------------------------
module opvd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  opvd_pkg::t_entry i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output opvd_pkg::t_entry o_data
);
    import opvd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_next(r_rd_ptr);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue pushed when full or popped when empty");
`endif
endmodule

// ===== src/opvd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opvd_back - fixed-point scaler
// Five-stage pipeline: reciprocal quotient, remainder, correction, fraction
// bits, sign and output register. Power-of-two divisors take a plain shift.
// ----------------------------------------------------------------------------
module opvd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  opvd_pkg::t_entry i_entry,
    output logic             o_pop,
    opvd_out_if.source       o_result
);
    import opvd_pkg::*;

    logic advance;

    logic                   r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    t_entry                 r1_e, r2_e, r3_e, r4_e;
    logic [31:0]            r1_q0, r2_q0, r3_q;
    logic [QR_W:0]          r2_r0;
    logic [QR_W-1:0]        r3_r;
    logic [FX_W-1:0]        r4_int;
    logic [FRACTION_BITS-1:0] r4_frac;
    logic signed [VALUE_WIDTH-1:0] r5_value;
    logic                   r5_rec, r5_map;
    logic [1:0]             r5_grp;

    logic [63:0]            n1_prod;
    logic [31+QR_W:0]       n2_prod;
    logic [MAG_W:0]         n2_diff;
    logic [QR_W-1:0]        n3_den;
    logic [QR_W+M_W-1:0]    n4_prod;
    logic [FX_W-1:0]        n5_sum;

    // hold every stage while the result waits
    assign advance = !(r5_valid && !o_result.ready);
    assign o_pop   = advance && !i_empty;

    assign n1_prod = 64'(i_entry.mag) * 64'(den_recip_q(i_entry.den));
    assign n2_prod = (32 + QR_W)'(r1_q0) * (32 + QR_W)'(den_value(r1_e.den));
    assign n2_diff = {1'b0, r1_e.mag} - {1'b0, n2_prod[MAG_W-1:0]};
    assign n3_den  = den_value(r2_e.den);
    assign n4_prod = (QR_W + M_W)'(r3_r) * (QR_W + M_W)'(den_recip_m(r3_e.den));
    assign n5_sum  = r4_int + FX_W'(r4_frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (advance) begin
            r1_valid <= !i_empty;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_e  <= i_entry;
            r1_q0 <= n1_prod[63:32];

            r2_e  <= r1_e;
            r2_q0 <= r1_q0;
            r2_r0 <= n2_diff[QR_W:0];

            // estimate can be one short
            r3_e <= r2_e;
            if (r2_r0 >= (QR_W + 1)'(n3_den)) begin
                r3_q <= r2_q0 + 32'd1;
                r3_r <= QR_W'(r2_r0 - (QR_W + 1)'(n3_den));
            end else begin
                r3_q <= r2_q0;
                r3_r <= r2_r0[QR_W-1:0];
            end

            r4_e <= r3_e;
            if (den_is_pow2(r3_e.den)) begin
                r4_int  <= FX_W'(r3_e.mag) << (FRACTION_BITS - den_log2(r3_e.den));
                r4_frac <= '0;
            end else begin
                r4_int  <= {r3_q, {FRACTION_BITS{1'b0}}};
                r4_frac <= n4_prod[M_SHIFT +: FRACTION_BITS];
            end

            r5_value <= r4_e.neg ? $signed(VALUE_WIDTH'(-n5_sum)) : $signed(VALUE_WIDTH'(n5_sum));
            r5_rec   <= r4_e.rec;
            r5_map   <= r4_e.map;
            r5_grp   <= r4_e.grp;
        end
    end

    assign o_result.valid          = r5_valid;
    assign o_result.scaled_value   = r5_value;
    assign o_result.recognised     = r5_rec;
    assign o_result.is_support_map = r5_map;
    assign o_result.map_group      = r5_grp;

`ifndef NO_ASSERTIONS
    a_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_valid && r5_map) |-> (r5_value == '0 && r5_rec))
        else $error("support map result carries a value");
`endif
endmodule

// ===== src/obd_pid_value_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pid_value_decoder_core - OBD-II mode 01 PID value decoder
// Decodes one response per cycle, while the result is accepted, into a signed fixed-point physical value.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  i_item     in   valid/ready   pid_code, data_a..data_d
//  o_result   out  valid/ready   scaled_value, recognised, is_support_map,
//                                map_group
//
//  One response per cycle sustained while o_result is ready; each response
//  passes through the queue and the scaler pipeline (quotient, remainder,
//  correction, fraction, sign) before its result is valid.
//  Synchronous active-low reset clears the pipeline, the queue and the
//  three support maps.
//  A stalled result holds the scaler; the two-entry queue keeps the input
//  side open until it fills.
// ----------------------------------------------------------------------------
module obd_pid_value_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    opvd_in_if.sink    i_item,
    opvd_out_if.source o_result
);
    import opvd_pkg::*;

    t_entry push_entry, head_entry;
    logic   push, full, pop, empty;

    opvd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    opvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_entry)
    );

    opvd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule
